### sv/aqet_pkg.sv
// Shared types, codes and constants of the agent quota enforcement table.
package aqet_pkg;

  localparam int unsigned NumSlotsDefault = 16;

  typedef enum logic [1:0] {
    MODE_REGISTER = 2'd0,
    MODE_TICK     = 2'd1,
    MODE_STATUS   = 2'd2,
    MODE_SET      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_UPDATE = 2'd2,
    S_OUT    = 2'd3
  } state_e;

  localparam int unsigned FlagActive = 0;
  localparam int unsigned FlagCpu    = 1;
  localparam int unsigned FlagMem    = 2;
  localparam int unsigned FlagRevoke = 3;

  localparam logic [31:0] CpuSat = 32'hFFFF_FFFF;

  // One slot's contents.
  typedef struct packed {
    logic [31:0] agent;
    logic [31:0] cpu_limit;
    logic [31:0] mem_limit;
    logic [31:0] cpu_used;
    logic [31:0] mem_used;
    logic [3:0]  flags;
  } slot_t;

  // Search token passed down the row of cells.
  typedef struct packed {
    logic        hit;
    logic        free;
    logic [7:0]  hit_idx;
    logic [7:0]  free_idx;
  } srch_t;

  // Write command broadcast to the cells.
  typedef struct packed {
    logic        we;
    logic [7:0]  idx;
    slot_t       data;
  } wcmd_t;

endpackage

### sv/aqet_cell.sv
// One table slot: stores its entry and folds its match into the search token.
module aqet_cell #(
  parameter int unsigned Index = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [31:0]     id_i,
  input  aqet_pkg::srch_t srch_i,
  output aqet_pkg::srch_t srch_o,
  input  aqet_pkg::wcmd_t wcmd_i,
  output aqet_pkg::slot_t slot_o
);

  aqet_pkg::slot_t slot_q;
  logic            act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (wcmd_i.we && wcmd_i.idx == 8'(Index)) begin
      slot_q <= wcmd_i.data;
    end
  end

  assign act = slot_q.flags[aqet_pkg::FlagActive];

  // Lowest index wins: keep the upstream result once it is set.
  always_comb begin
    srch_o = srch_i;
    if (!srch_i.hit && act && slot_q.agent == id_i) begin
      srch_o.hit     = 1'b1;
      srch_o.hit_idx = 8'(Index);
    end
    if (!srch_i.free && !act) begin
      srch_o.free     = 1'b1;
      srch_o.free_idx = 8'(Index);
    end
  end

  assign slot_o = slot_q;

endmodule

### sv/agent_quota_enforcement_table_unit.sv
// Top level of the agent quota enforcement table: slot row, sequencer, output register.
// An accepted item passes through the scan and update states before its result is valid.
// A new item is accepted only in the idle state, once the previous result has been taken;
//   each item passes the search over the row of slot cells, the update state and the handoff.
// Reset: asynchronous, active low; all slots inactive and zero, no result pending.
// No clearing pass is needed after reset.
module agent_quota_enforcement_table_unit #(
  parameter int unsigned NUM_SLOTS = aqet_pkg::NumSlotsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] mode, [33:2] agent, [65:34] cpu_amount, [97:66] mem_amount, zero pad to 104
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] status, [5:2] slot_index, [6] already_registered, [38:7] cpu_used,
  // [70:39] cpu_limit, [102:71] mem_used, [134:103] mem_limit, [138:135] slot_flags,
  // [139] revoke_now, [141:140] revoke_reason, zero pad to 144
  output logic [143:0] m_axis_tdata
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  aqet_pkg::state_e state_q, state_d;
  logic [1:0]  mode_q;
  logic [31:0] id_q, cpu_q, mem_q;
  aqet_pkg::srch_t res_q;
  aqet_pkg::slot_t cur_q;
  logic [143:0] out_q, out_d;
  aqet_pkg::wcmd_t wcmd;

  aqet_pkg::srch_t chain [NUM_SLOTS+1];
  aqet_pkg::slot_t slots [NUM_SLOTS];

  assign chain[0] = '0;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    aqet_cell #(.Index(g)) u_cell (
      .clk_i (clk_i), .rst_ni(rst_ni), .id_i(id_q),
      .srch_i(chain[g]), .srch_o(chain[g+1]),
      .wcmd_i(wcmd), .slot_o(slots[g])
    );
  end

  assign s_axis_tready = (state_q == aqet_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aqet_pkg::S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (state_q == aqet_pkg::S_UPDATE) m_axis_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q <= s_axis_tdata[1:0];
      id_q   <= s_axis_tdata[33:2];
      cpu_q  <= s_axis_tdata[65:34];
      mem_q  <= s_axis_tdata[97:66];
    end
    if (state_q == aqet_pkg::S_SCAN) begin
      res_q <= chain[NUM_SLOTS];
      cur_q <= slots[chain[NUM_SLOTS].hit_idx[IdxW-1:0]];
    end
    if (state_q == aqet_pkg::S_UPDATE) out_q <= out_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      aqet_pkg::S_IDLE:   if (s_axis_tvalid) state_d = aqet_pkg::S_SCAN;
      aqet_pkg::S_SCAN:   state_d = aqet_pkg::S_UPDATE;
      aqet_pkg::S_UPDATE: state_d = aqet_pkg::S_OUT;
      aqet_pkg::S_OUT:    if (!m_axis_tvalid || m_axis_tready) state_d = aqet_pkg::S_IDLE;
      default:            state_d = aqet_pkg::S_IDLE;
    endcase
  end

  // Request evaluation on the registered search result.
  logic [1:0]  st;
  logic [7:0]  sidx;
  logic        already, rv;
  logic [1:0]  reason;
  logic [3:0]  f;
  logic [32:0] sum;
  logic [31:0] sat;
  logic        fresh;
  logic [127:0] stat;
  always_comb begin
    st = aqet_pkg::ST_OK;
    sidx = res_q.hit_idx;
    already = 1'b0;
    rv = 1'b0;
    reason = 2'b00;
    f = cur_q.flags;
    stat = '0;
    fresh = 1'b0;
    sum = {1'b0, cur_q.cpu_used} + {1'b0, cpu_q};
    sat = sum[32] ? aqet_pkg::CpuSat : sum[31:0];
    wcmd = '0;
    wcmd.idx = res_q.hit_idx;
    wcmd.data = cur_q;
    if (mode_q == aqet_pkg::MODE_REGISTER) begin
      if (res_q.hit) begin
        already = 1'b1;
      end else if (!res_q.free) begin
        st = aqet_pkg::ST_FULL;
        sidx = '0;
        f = '0;
      end else begin
        sidx = res_q.free_idx;
        f = 4'b0001;
        wcmd.idx = res_q.free_idx;
        wcmd.data = '{agent: id_q, cpu_limit: cpu_q, mem_limit: mem_q,
                      cpu_used: '0, mem_used: '0, flags: 4'b0001};
      end
      wcmd.we = (state_q == aqet_pkg::S_UPDATE) && !res_q.hit && res_q.free;
    end else if (!res_q.hit) begin
      st = aqet_pkg::ST_NOTFOUND;
      sidx = '0;
      f = '0;
    end else begin
      case (mode_q)
        aqet_pkg::MODE_TICK: begin
          if (!f[aqet_pkg::FlagRevoke]) begin
            if (cur_q.cpu_limit != 0 && sat >= cur_q.cpu_limit && !f[aqet_pkg::FlagCpu]) begin
              f[aqet_pkg::FlagCpu] = 1'b1;
              fresh = 1'b1;
            end
            if (cur_q.mem_limit != 0 && mem_q >= cur_q.mem_limit && !f[aqet_pkg::FlagMem]) begin
              f[aqet_pkg::FlagMem] = 1'b1;
              fresh = 1'b1;
            end
            if (fresh) begin
              f[aqet_pkg::FlagRevoke] = 1'b1;
              rv = 1'b1;
              reason = {f[aqet_pkg::FlagMem], f[aqet_pkg::FlagCpu]};
            end
          end
          wcmd.data.cpu_used = sat;
          wcmd.data.mem_used = mem_q;
          wcmd.data.flags = f;
          wcmd.we = (state_q == aqet_pkg::S_UPDATE);
        end
        aqet_pkg::MODE_STATUS: begin
          stat = {cur_q.mem_limit, cur_q.mem_used, cur_q.cpu_limit, cur_q.cpu_used};
        end
        default: begin
          if (cpu_q == 0 || cur_q.cpu_used < cpu_q) f[aqet_pkg::FlagCpu] = 1'b0;
          if (mem_q == 0 || cur_q.mem_used < mem_q) f[aqet_pkg::FlagMem] = 1'b0;
          if (!f[aqet_pkg::FlagCpu] && !f[aqet_pkg::FlagMem]) f[aqet_pkg::FlagRevoke] = 1'b0;
          wcmd.data.cpu_limit = cpu_q;
          wcmd.data.mem_limit = mem_q;
          wcmd.data.flags = f;
          wcmd.we = (state_q == aqet_pkg::S_UPDATE);
        end
      endcase
    end
    out_d = {2'b00, reason, rv, f, stat, already, sidx[3:0], st};
  end

  assign m_axis_tdata = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aqet_pkg::S_UPDATE) |=> m_axis_tvalid)
    else $error("result not raised after update");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !wcmd.we)
    else $error("table written while a result is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[139] |-> m_axis_tdata[138])
    else $error("revoke pulse without revoked flag");

endmodule

### tb/agent_quota_enforcement_table_unit_tb.sv
// Self-checking testbench of the agent quota enforcement table, with its own slot predictor.
`timescale 1ns / 100ps

module agent_quota_enforcement_table_unit_tb;

  localparam int unsigned NSLOT = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic        already_registered;
    logic [31:0] cpu_used;
    logic [31:0] cpu_limit;
    logic [31:0] mem_used;
    logic [31:0] mem_limit;
    logic [3:0]  slot_flags;
    logic        revoke_now;
    logic [1:0]  revoke_reason;
  } answer_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;

  agent_quota_enforcement_table_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predictor copy of the slot table.
  logic [31:0] tbl_agent   [NSLOT];
  logic [31:0] tbl_cpu_lim [NSLOT];
  logic [31:0] tbl_mem_lim [NSLOT];
  logic [31:0] tbl_cpu_use [NSLOT];
  logic [31:0] tbl_mem_use [NSLOT];
  logic [3:0]  tbl_flags   [NSLOT];

  logic [103:0] pending_items[$];
  answer_t      expected_answers[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_cycles;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned answers_seen;
  int unsigned revokes_seen;

  logic [31:0] id_pool[8];

  function automatic answer_t predict_request(logic [103:0] item);
    answer_t         a;
    aqet_pkg::mode_e m;
    logic [31:0]     id, cpu, mem, sum;
    logic [3:0]      f;
    int              s, fr;
    bit              fresh;
    m   = aqet_pkg::mode_e'(item[1:0]);
    id  = item[33:2];
    cpu = item[65:34];
    mem = item[97:66];
    a   = '0;
    s   = -1;
    fr  = -1;
    fresh = 0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (tbl_flags[i][aqet_pkg::FlagActive] && tbl_agent[i] == id) s = i;
      if (!tbl_flags[i][aqet_pkg::FlagActive]) fr = i;
    end
    if (m == aqet_pkg::MODE_REGISTER) begin
      if (s >= 0) begin
        a.slot_index = s[3:0];
        a.already_registered = 1'b1;
        a.slot_flags = tbl_flags[s];
      end else if (fr < 0) begin
        a.status = aqet_pkg::ST_FULL;
      end else begin
        tbl_agent[fr]   = id;
        tbl_cpu_lim[fr] = cpu;
        tbl_mem_lim[fr] = mem;
        tbl_cpu_use[fr] = '0;
        tbl_mem_use[fr] = '0;
        tbl_flags[fr]   = 4'b0001;
        a.slot_index = fr[3:0];
        a.slot_flags = 4'b0001;
      end
      return a;
    end
    if (s < 0) begin
      a.status = aqet_pkg::ST_NOTFOUND;
      return a;
    end
    a.slot_index = s[3:0];
    f = tbl_flags[s];
    case (m)
      aqet_pkg::MODE_TICK: begin
        sum = tbl_cpu_use[s] + cpu;
        if (sum < cpu) sum = aqet_pkg::CpuSat;
        tbl_cpu_use[s] = sum;
        tbl_mem_use[s] = mem;
        if (!f[aqet_pkg::FlagRevoke]) begin
          if (tbl_cpu_lim[s] != 0 && sum >= tbl_cpu_lim[s] && !f[aqet_pkg::FlagCpu]) begin
            f[aqet_pkg::FlagCpu] = 1'b1;
            fresh = 1;
          end
          if (tbl_mem_lim[s] != 0 && mem >= tbl_mem_lim[s] && !f[aqet_pkg::FlagMem]) begin
            f[aqet_pkg::FlagMem] = 1'b1;
            fresh = 1;
          end
          if (fresh) begin
            f[aqet_pkg::FlagRevoke] = 1'b1;
            a.revoke_now = 1'b1;
            a.revoke_reason = {f[aqet_pkg::FlagMem], f[aqet_pkg::FlagCpu]};
          end
        end
        tbl_flags[s] = f;
      end
      aqet_pkg::MODE_STATUS: begin
        a.cpu_used  = tbl_cpu_use[s];
        a.cpu_limit = tbl_cpu_lim[s];
        a.mem_used  = tbl_mem_use[s];
        a.mem_limit = tbl_mem_lim[s];
      end
      default: begin
        tbl_cpu_lim[s] = cpu;
        tbl_mem_lim[s] = mem;
        if (cpu == 0 || tbl_cpu_use[s] < cpu) f[aqet_pkg::FlagCpu] = 1'b0;
        if (mem == 0 || tbl_mem_use[s] < mem) f[aqet_pkg::FlagMem] = 1'b0;
        if (!f[aqet_pkg::FlagCpu] && !f[aqet_pkg::FlagMem]) f[aqet_pkg::FlagRevoke] = 1'b0;
        tbl_flags[s] = f;
      end
    endcase
    a.slot_flags = f;
    return a;
  endfunction

  function automatic answer_t unpack_answer(logic [143:0] d);
    answer_t a;
    a.status             = d[1:0];
    a.slot_index         = d[5:2];
    a.already_registered = d[6];
    a.cpu_used           = d[38:7];
    a.cpu_limit          = d[70:39];
    a.mem_used           = d[102:71];
    a.mem_limit          = d[134:103];
    a.slot_flags         = d[138:135];
    a.revoke_now         = d[139];
    a.revoke_reason      = d[141:140];
    return a;
  endfunction

  task automatic push_request(aqet_pkg::mode_e m, logic [31:0] id, logic [31:0] cpu,
                              logic [31:0] mem);
    pending_items.push_back({6'd0, mem, cpu, id, m});
  endtask

  // Amount biased toward the edges and toward small values that hit limits.
  function automatic logic [31:0] pick_amount();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      3: return 32'hFFFF_FFFF - $urandom_range(0, 50);
      default: return $urandom_range(0, 200);
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_items.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Prediction at acceptance, in program order.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_answers.push_back(predict_request(s_axis_tdata));
  end

  // Receiver ready, with a long hold-off when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      m_axis_tready   <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = unpack_answer(m_axis_tdata);
      answers_seen <= answers_seen + 1;
      if (got.revoke_now) revokes_seen <= revokes_seen + 1;
      if (expected_answers.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result item %h", m_axis_tdata);
      end else begin
        want = expected_answers.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("agent_quota_enforcement_table_unit: mismatch");
      $finish;
    end
  end

  initial begin
    logic [31:0]     id;
    aqet_pkg::mode_e m;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_agent[i] = '0; tbl_cpu_lim[i] = '0; tbl_mem_lim[i] = '0;
      tbl_cpu_use[i] = '0; tbl_mem_use[i] = '0; tbl_flags[i] = '0;
    end
    send_idle_pct = 14; recv_idle_pct = 58; hold_off_cycles = 0;
    cycle_count = 0; mismatches = 0; answers_seen = 0; revokes_seen = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unknown agent, register, already registered, saturation,
    // revoke, tick on revoked slot, set clearing, then fill the table.
    push_request(aqet_pkg::MODE_STATUS, 32'h0, 0, 0);
    push_request(aqet_pkg::MODE_TICK, 32'hFFFF_FFFF, 5, 5);
    push_request(aqet_pkg::MODE_REGISTER, 32'h0, 100, 50);
    push_request(aqet_pkg::MODE_REGISTER, 32'h0, 7, 7);
    push_request(aqet_pkg::MODE_REGISTER, 32'hFFFF_FFFF, 0, 0);
    push_request(aqet_pkg::MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    push_request(aqet_pkg::MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    push_request(aqet_pkg::MODE_STATUS, 32'hFFFF_FFFF, 0, 0);
    push_request(aqet_pkg::MODE_TICK, 32'h0, 60, 10);
    push_request(aqet_pkg::MODE_TICK, 32'h0, 40, 60);
    push_request(aqet_pkg::MODE_TICK, 32'h0, 40, 70);
    push_request(aqet_pkg::MODE_STATUS, 32'h0, 0, 0);
    push_request(aqet_pkg::MODE_SET, 32'h0, 500, 0);
    push_request(aqet_pkg::MODE_TICK, 32'h0, 0, 80);
    push_request(aqet_pkg::MODE_SET, 32'h0, 100, 0);
    push_request(aqet_pkg::MODE_SET, 32'h0, 0, 0);
    push_request(aqet_pkg::MODE_STATUS, 32'h0, 0, 0);
    for (int i = 2; i < 17; i++) push_request(aqet_pkg::MODE_REGISTER, 32'h100 + i, 1, 1);
    push_request(aqet_pkg::MODE_SET, 32'h5A5A_5A5A, 1, 1);

    // Random: mostly ticks, status and sets on a small pool of agents.
    for (int i = 0; i < 8; i++) id_pool[i] = (i == 0) ? 32'h0 : $urandom();
    for (int i = 0; i < 730; i++) begin
      if (i == 240) begin
        while (pending_items.size() != 0 || expected_answers.size() != 0)
          @(posedge clk_i);
        send_idle_pct = 58; recv_idle_pct = 14;
      end
      if (i == 480) begin
        while (pending_items.size() != 0 || expected_answers.size() != 0)
          @(posedge clk_i);
        send_idle_pct = 0; recv_idle_pct = 0;
        hold_off_cycles = 300;
      end
      id = ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, 7)];
      m  = aqet_pkg::mode_e'($urandom_range(0, 3));
      push_request(m, id, pick_amount(), pick_amount());
    end
    // A flood for a full table before the end.
    for (int i = 0; i < 20; i++) push_request(aqet_pkg::MODE_REGISTER, $urandom(), $urandom(), 0);

    while (pending_items.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("checked %0d results over register, tick, status and set, %0d revokes seen",
             answers_seen, revokes_seen);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("agent_quota_enforcement_table_unit: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("agent_quota_enforcement_table_unit: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
sv/aqet_pkg.sv
sv/aqet_cell.sv
sv/agent_quota_enforcement_table_unit.sv
tb/agent_quota_enforcement_table_unit_tb.sv
